// ----- hdl/jia_pkg.sv -----
// ----------------------------------------------------------------------------
// jia_pkg
// shared types and constants for the integer alu
// ----------------------------------------------------------------------------
package jia_pkg;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_REM  = 4'd4,
    CMD_AND  = 4'd5,
    CMD_OR   = 4'd6,
    CMD_XOR  = 4'd7,
    CMD_SHL  = 4'd8,
    CMD_SHR  = 4'd9,
    CMD_USHR = 4'd10
  } cmd_t;

  typedef struct packed {
    logic [3:0]  command;
    logic        wide;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result;
    logic        divide_by_zero;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [3:0]  command;
    logic        wide;
    logic [63:0] a;
    logic [63:0] b;
  } op_t;

endpackage

// ----- hdl/jia_front.sv -----
// ----------------------------------------------------------------------------
// jia_front
// accepts items, sign-extends operands in int mode, buffers them in a
// small queue in front of the execution pipeline
// ----------------------------------------------------------------------------
module jia_front #(
  parameter int Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  jia_pkg::in_item_t in_item,
  output logic              op_valid,
  output jia_pkg::op_t      op,
  input  logic              op_take
);
  import jia_pkg::*;

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  op_t            mem [Depth];
  logic [Aw-1:0]  wr_ptr;
  logic [Aw-1:0]  rd_ptr;
  logic [Aw:0]    count;
  op_t            cls;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    cls.command = in_item.command;
    cls.wide    = in_item.wide;
    cls.a = in_item.wide ? in_item.operand_a
                         : {{32{in_item.operand_a[31]}}, in_item.operand_a[31:0]};
    cls.b = in_item.wide ? in_item.operand_b
                         : {{32{in_item.operand_b[31]}}, in_item.operand_b[31:0]};
  end

  assign full     = (count == (Aw+1)'(Depth));
  assign op_valid = (count != '0);
  assign op       = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = op_take && op_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

endmodule

// ----- hdl/jia_mul.sv -----
// ----------------------------------------------------------------------------
// jia_mul
// 64x64 low-half multiplier from registered 32x32 partial products, summed after
// ----------------------------------------------------------------------------
module jia_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[31:0] * b[31:0];
      lh <= 32'(a[31:0] * b[63:32]);
      hl <= 32'(a[63:32] * b[31:0]);
    end
  end

  assign p = ll + {lh + hl, 32'd0};

endmodule

// ----- hdl/jia_div.sv -----
// ----------------------------------------------------------------------------
// jia_div
// pipelined signed divider, one quotient bit per stage over 64 stages
// ----------------------------------------------------------------------------
module jia_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        out_valid,
  output logic [63:0] quo,
  output logic [63:0] rem
);
  localparam int N = 64;

  logic [N-1:0] q   [N+1];
  logic [N-1:0] r   [N+1];
  logic [N-1:0] d   [N+1];
  logic         nq  [N+1];
  logic         nr  [N+1];
  logic         vld [N+1];

  always_comb begin
    q[0]   = a[63] ? (64'd0 - a) : a;
    d[0]   = b[63] ? (64'd0 - b) : b;
    r[0]   = '0;
    nq[0]  = a[63] ^ b[63];
    nr[0]  = a[63];
    vld[0] = in_valid;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N:0] trial;
    logic [N:0] diff;
    assign trial = {r[i], q[i][N-1]};
    assign diff  = trial - {1'b0, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        d[i+1]  <= d[i];
        nq[i+1] <= nq[i];
        nr[i+1] <= nr[i];
        if (!diff[N]) begin
          r[i+1] <= diff[N-1:0];
          q[i+1] <= {q[i][N-2:0], 1'b1};
        end else begin
          r[i+1] <= trial[N-1:0];
          q[i+1] <= {q[i][N-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign quo = nq[N] ? (64'd0 - q[N]) : q[N];
  assign rem = nr[N] ? (64'd0 - r[N]) : r[N];

endmodule

// ----- hdl/jia_back.sv -----
// ----------------------------------------------------------------------------
// jia_back
// execution pipeline: simple ops, multiplier and divider in lockstep,
// results written into an output queue; the whole pipeline holds when the
// queue is full and a finished item is waiting that is not being popped
module jia_back #(
  parameter int OutDepth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  jia_pkg::op_t       op,
  output logic               op_take,
  output logic               empty,
  input  logic               pop,
  output jia_pkg::out_item_t out_item
);
  import jia_pkg::*;

  localparam int Lat = 64;
  localparam int Ow  = (OutDepth > 1) ? $clog2(OutDepth) : 1;

  logic          adv;
  logic          issue;
  logic          take_out;
  logic          put;
  logic          oq_full;

  logic [63:0]   simple;
  logic [5:0]    sh;
  logic          dz;

  logic [3:0]    cmd_p  [Lat+1];
  logic          wide_p [Lat+1];
  logic [63:0]   res_p  [Lat+1];
  logic          dz_p   [Lat+1];

  logic [63:0]   mul_p;
  logic [63:0]   quo;
  logic [63:0]   remv;
  logic          div_v;
  logic [63:0]   fin;
  logic [63:0]   fin_x;

  out_item_t     oq [OutDepth];
  logic [Ow-1:0] wr_ptr;
  logic [Ow-1:0] rd_ptr;
  logic [Ow:0]   count;

  // hold the pipeline only when a finished item has nowhere to go
  assign oq_full  = (count == (Ow+1)'(OutDepth));
  assign take_out = pop && !empty;
  assign adv      = !div_v || !oq_full || take_out;
  assign put      = div_v && adv;
  assign issue    = op_valid && adv;
  assign op_take  = issue;

  always_comb begin
    sh     = op.wide ? op.b[5:0] : {1'b0, op.b[4:0]};
    dz     = (op.b == 64'd0);
    simple = '0;
    case (op.command)
      CMD_ADD:  simple = op.a + op.b;
      CMD_SUB:  simple = op.a - op.b;
      CMD_AND:  simple = op.a & op.b;
      CMD_OR:   simple = op.a | op.b;
      CMD_XOR:  simple = op.a ^ op.b;
      CMD_SHL:  simple = op.a << sh;
      CMD_SHR:  simple = 64'($signed(op.a) >>> sh);
      CMD_USHR: simple = op.wide ? (op.a >> sh) : ({32'd0, op.a[31:0]} >> sh);
      default:  simple = '0;
    endcase
  end

  always_comb begin
    cmd_p[0]  = op.command;
    wide_p[0] = op.wide;
    res_p[0]  = simple;
    dz_p[0]   = dz && (op.command == CMD_DIV || op.command == CMD_REM);
  end

  for (genvar i = 0; i < Lat; i++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (adv) begin
        cmd_p[i+1]  <= cmd_p[i];
        wide_p[i+1] <= wide_p[i];
        res_p[i+1]  <= res_p[i];
        dz_p[i+1]   <= dz_p[i];
      end
    end
  end

  jia_mul u_mul (
    .clk (clk),
    .en  (adv),
    .a   (op.a),
    .b   (op.b),
    .p   (mul_p)
  );

  jia_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (issue),
    .a         (op.a),
    .b         (dz ? 64'd1 : op.b),
    .out_valid (div_v),
    .quo       (quo),
    .rem       (remv)
  );

  // carry the product down the remaining stages
  logic [63:0] mul_d [Lat];
  assign mul_d[0] = mul_p;
  for (genvar j = 1; j < Lat; j++) begin : g_mul
    always_ff @(posedge clk) begin
      if (adv) begin
        mul_d[j] <= mul_d[j-1];
      end
    end
  end

  always_comb begin
    case (cmd_p[Lat])
      CMD_MUL: fin = mul_d[Lat-1];
      CMD_DIV: fin = dz_p[Lat] ? 64'd0 : quo;
      CMD_REM: fin = dz_p[Lat] ? 64'd0 : remv;
      default: fin = res_p[Lat];
    endcase
    fin_x = wide_p[Lat] ? fin : {{32{fin[31]}}, fin[31:0]};
  end

  always_ff @(posedge clk) begin
    if (put) begin
      oq[wr_ptr] <= '{result: fin_x, divide_by_zero: dz_p[Lat]};
    end
  end

  assign empty    = (count == '0);
  assign out_item = oq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (put) begin
        wr_ptr <= (wr_ptr == Ow'(OutDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take_out) begin
        rd_ptr <= (rd_ptr == Ow'(OutDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Ow+1)'(put) - (Ow+1)'(take_out);
    end
  end

endmodule

// ----- hdl/jvm_integer_alu_core.sv -----
// throughput: one item per cycle through the 64-stage divider and multiplier pipeline;
// but a full output queue with a finished item waiting freezes the pipeline, then push
// stalls once the input queue fills
// reset: synchronous, clears both queues and all pipeline valid bits
// ----------------------------------------------------------------------------
// jvm_integer_alu_core
// integer alu with java bytecode semantics, 32 and 64 bit
// ----------------------------------------------------------------------------
module jvm_integer_alu_core #(
  parameter int InDepth  = 4,
  parameter int OutDepth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  jia_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output jia_pkg::out_item_t out_item
);
  import jia_pkg::*;

  logic op_valid;
  op_t  op;
  logic op_take;

  jia_front #(.Depth(InDepth)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  jia_back #(.OutDepth(OutDepth)) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ----- verif/tb_jvm_integer_alu_core.sv -----
// ----------------------------------------------------------------------------
// tb_jvm_integer_alu_core
// self-checking testbench for the java-semantics integer alu: a predictor
// works out each result as items are accepted, a checker compares results
// in order; directed, random, backpressure and drain-pause tests run in turn
// ----------------------------------------------------------------------------
module tb_jvm_integer_alu_core;
  timeunit 1ns;
  timeprecision 1ps;

  import jia_pkg::*;

  localparam logic [63:0] LONG_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LONG_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] INT_MIN  = 64'hffff_ffff_8000_0000;
  localparam logic [63:0] INT_MAX  = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] MINUS1   = 64'hffff_ffff_ffff_ffff;
  localparam logic [3:0]  FIRST_UNUSED_CMD = 4'd11;
  localparam logic [3:0]  LAST_UNUSED_CMD  = 4'd15;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;

  out_item_t  pending_results[$];
  int         error_count;
  int         cycle_count;
  logic       tx_idle_en;
  logic       rx_idle_en;
  logic       rx_hold;
  int         rx_wait;

  jvm_integer_alu_core DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sext32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t   o;
    logic [63:0] a, b, ua, ub, uq, ur, r;
    logic [5:0]  s;
    logic        na, nb;
    a = it.wide ? it.operand_a : sext32(it.operand_a);
    b = it.wide ? it.operand_b : sext32(it.operand_b);
    s = it.wide ? b[5:0] : {1'b0, b[4:0]};
    r = '0;
    o.divide_by_zero = 1'b0;
    case (it.command)
      CMD_ADD:  r = a + b;
      CMD_SUB:  r = a - b;
      CMD_MUL:  r = a * b;
      CMD_DIV, CMD_REM: begin
        if (b == '0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          na = a[63];
          nb = b[63];
          ua = na ? -a : a;
          ub = nb ? -b : b;
          uq = ua / ub;
          ur = ua % ub;
          if (it.command == CMD_DIV) r = (na != nb) ? -uq : uq;
          else r = na ? -ur : ur;
        end
      end
      CMD_AND:  r = a & b;
      CMD_OR:   r = a | b;
      CMD_XOR:  r = a ^ b;
      CMD_SHL:  r = a << s;
      CMD_SHR:  r = $signed(a) >>> s;
      CMD_USHR: r = it.wide ? (a >> s) : ({32'b0, a[31:0]} >> s);
      default:  r = '0;
    endcase
    o.result = it.wide ? r : sext32(r);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // sender: optional gap, then hold push until the item is taken
  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(push && !full));
    pending_results.push_back(alu_predict(it));
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_op(logic [3:0] cmd, logic w, logic [63:0] a, logic [63:0] b);
    in_item_t it;
    it.command = cmd;
    it.wide = w;
    it.operand_a = a;
    it.operand_b = b;
    send_item(it);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = LONG_MIN;
      1: v = LONG_MAX;
      2: v = {$urandom, 32'h8000_0000 | ($urandom & 32'h1)};
      3: v = {$urandom, 32'h7fff_ffff};
      4: v = 64'($signed($urandom_range(0, 8)) - 4);
      5: v = {$urandom, 32'h0};
      6: v = sext32({32'b0, $urandom});
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    if ($urandom_range(0, 19) == 0) it.command = 4'($urandom_range(11, 15));
    else it.command = 4'($urandom_range(0, 10));
    it.wide = 1'($urandom_range(0, 1));
    it.operand_a = rand_operand();
    it.operand_b = rand_operand();
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [3:0] c;
    for (int i = 0; i <= CMD_USHR; i++) begin
      c = 4'(i);
      send_op(c, i[0], LONG_MIN, MINUS1);
    end
    send_op(CMD_DIV, 1'b1, LONG_MIN, MINUS1);
    send_op(CMD_REM, 1'b1, LONG_MIN, MINUS1);
    send_op(CMD_DIV, 1'b0, INT_MIN, MINUS1);
    send_op(CMD_REM, 1'b0, 64'h1234_5678_8000_0000, 64'h0000_0001_ffff_ffff);
    send_op(CMD_DIV, 1'b1, LONG_MAX, 64'h0);
    send_op(CMD_REM, 1'b1, LONG_MIN, 64'h0);
    send_op(CMD_DIV, 1'b0, INT_MAX, 64'hffff_ffff_0000_0000);
    send_op(CMD_REM, 1'b0, INT_MIN, 64'h0);
    send_op(CMD_DIV, 1'b1, 64'hffff_ffff_ffff_fff9, 64'h2);
    send_op(CMD_REM, 1'b1, 64'hffff_ffff_ffff_fff9, 64'hffff_ffff_ffff_fffe);
    send_op(CMD_SHL, 1'b0, INT_MAX, 64'hffff_ffff_ffff_ffe1);
    send_op(CMD_SHR, 1'b1, LONG_MIN, 64'hffff_ffff_ffff_ffff);
    send_op(CMD_USHR, 1'b0, MINUS1, 64'h0000_0007_0000_0040);
    send_op(CMD_ADD, 1'b0, 64'hdead_beef_7fff_ffff, 64'h1);
    send_op(FIRST_UNUSED_CMD, 1'b1, LONG_MAX, MINUS1);
    send_op(LAST_UNUSED_CMD, 1'b0, MINUS1, 64'h0);
    stop_sending();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en <= ($urandom_range(0, 3) != 0);
      end
      send_item(rand_item());
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        for (int i = 0; i < 150; i++) send_item(rand_item());
        stop_sending();
      end
    join
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_item(rand_item());
    stop_sending();
    wait_drained();
    for (int i = 0; i < 20; i++) send_item(rand_item());
    stop_sending();
  endtask

  // receiver
  always @(posedge clk) begin
    int w;
    if (rst) begin
      pop <= 1'b0;
      rx_wait <= 0;
    end else if (rx_hold) begin
      pop <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      pop <= 1'b0;
    end else if (pop && !empty) begin
      w = rx_idle_en ? $urandom_range(0, 5) : 0;
      rx_wait <= w;
      pop <= (w == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  // checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("unexpected item at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.result !== want.result)
          report_mismatch("result", out_item.result, want.result);
        if (out_item.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 64'(out_item.divide_by_zero),
                          64'(want.divide_by_zero));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_drain_pause();
    test_random(560);
    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
